// File: rtl/mcah_pkg.sv
// Shared types, codes and constants of the magnetometer calibration and heading block.
`default_nettype none

package mcah_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int AXIS_W     = 11;
    localparam int THR_W      = 15;
    localparam int COUNT_W    = 4;
    localparam int HEADING_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // CORDIC widths: vector holds 17-bit inputs scaled by 256 plus gain, angle in 1/32768 degree
    localparam int VEC_W          = 28;
    localparam int ANG_W          = 25;
    localparam int TAB_W          = 21;
    localparam int ATAN_MAX_STEPS = 24;
    localparam int RND_W          = 18;
    localparam int WRAP_W         = 19;

    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Result status codes
    localparam status_t ST_HEADING  = 3'd0;
    localparam status_t ST_USED     = 3'd1;
    localparam status_t ST_REJECTED = 3'd2;
    localparam status_t ST_FINISHED = 3'd3;
    localparam status_t ST_STARTED  = 3'd4;

    // Configuration register indexes
    localparam cfg_idx_t REG_REJECT_LIMIT   = 3'd0;
    localparam cfg_idx_t REG_ARM_THRESHOLD  = 3'd1;
    localparam cfg_idx_t REG_TURN_THRESHOLD = 3'd2;
    localparam cfg_idx_t REG_TURNS_NEEDED   = 3'd3;
    localparam cfg_idx_t REG_DECLINATION    = 3'd4;

    // Register reset values
    localparam logic [THR_W-1:0]          RST_REJECT_LIMIT   = 15'd600;
    localparam logic [THR_W-1:0]          RST_ARM_THRESHOLD  = 15'd40;
    localparam logic [THR_W-1:0]          RST_TURN_THRESHOLD = 15'd50;
    localparam logic [COUNT_W-1:0]        RST_TURNS_NEEDED   = 4'd3;
    localparam logic signed [SAMPLE_W-1:0] RST_DECLINATION   = 16'sd1320;

    // Axis saturation bounds and angle constants
    localparam logic signed [SAMPLE_W-1:0] AXIS_LO = -16'sd1024;
    localparam logic signed [SAMPLE_W-1:0] AXIS_HI = 16'sd1023;
    localparam logic signed [ANG_W-1:0]    QUARTER_ANGLE = 25'sd2949120;
    localparam logic signed [WRAP_W-1:0]   FULL_TURN     = 19'sd46080;
    localparam logic signed [WRAP_W-1:0]   TWO_TURNS     = 19'sd92160;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start_cal;
        logic reject;
        logic cal_update;
        logic cal_check;
        logic cord_init;
        logic cord_step;
        logic round;
        logic wrap;
        logic publish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic kind;
        logic calibrating;
        logic rejected;
        logic zero_vec;
        logic cord_last;
        logic out_space;
    } stat_t;

    // atan(2^-i) in units of 1/32768 degree, rounded
    function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] idx);
        logic [TAB_W-1:0] val;
        case (idx)
            5'd0:    val = 21'd1474560;
            5'd1:    val = 21'd870484;
            5'd2:    val = 21'd459940;
            5'd3:    val = 21'd233473;
            5'd4:    val = 21'd117189;
            5'd5:    val = 21'd58652;
            5'd6:    val = 21'd29333;
            5'd7:    val = 21'd14667;
            5'd8:    val = 21'd7334;
            5'd9:    val = 21'd3667;
            5'd10:   val = 21'd1833;
            5'd11:   val = 21'd917;
            5'd12:   val = 21'd458;
            5'd13:   val = 21'd229;
            5'd14:   val = 21'd115;
            5'd15:   val = 21'd57;
            5'd16:   val = 21'd29;
            5'd17:   val = 21'd14;
            5'd18:   val = 21'd7;
            5'd19:   val = 21'd4;
            5'd20:   val = 21'd2;
            5'd21:   val = 21'd1;
            default: val = 21'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mcah_if.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

// Input items: sample or start-calibration command
interface mcah_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [mcah_pkg::SAMPLE_W-1:0] raw_x;
    logic signed [mcah_pkg::SAMPLE_W-1:0] raw_y;
    logic signed [mcah_pkg::SAMPLE_W-1:0] raw_z;

    modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

// Result items: heading and status
interface mcah_out_if;
    logic                           valid;
    logic                           ready;
    logic [mcah_pkg::HEADING_W-1:0] heading;
    logic [mcah_pkg::STATUS_W-1:0]  status;

    modport source (output valid, heading, status, input ready);
    modport sink   (input valid, heading, status, output ready);
endinterface

// Configuration register writes
interface mcah_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mcah_pkg::CFG_IDX_W-1:0]  index;
    logic [mcah_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mcah_ctrl.sv
// Sequencing state machine: steps the datapath through one item at a time.
`default_nettype none

module mcah_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mcah_pkg::stat_t stat,
    output mcah_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_START     = 4'd2;
    localparam logic [3:0] S_CAL_UPD   = 4'd3;
    localparam logic [3:0] S_CAL_CHK   = 4'd4;
    localparam logic [3:0] S_CORD_INIT = 4'd5;
    localparam logic [3:0] S_CORD_ITER = 4'd6;
    localparam logic [3:0] S_ROUND     = 4'd7;
    localparam logic [3:0] S_WRAP      = 4'd8;
    localparam logic [3:0] S_DELIVER   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.kind)
                    state_next = S_START;
                else if (stat.calibrating)
                    state_next = S_CAL_UPD;
                else
                    state_next = S_CORD_INIT;
            end
            S_START:
            begin
                cmd.start_cal = 1'b1;
                state_next    = S_DELIVER;
            end
            S_CAL_UPD:
            begin
                if (stat.rejected)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_DELIVER;
                end
                else
                begin
                    cmd.cal_update = 1'b1;
                    state_next     = S_CAL_CHK;
                end
            end
            S_CAL_CHK:
            begin
                cmd.cal_check = 1'b1;
                state_next    = S_DELIVER;
            end
            S_CORD_INIT:
            begin
                cmd.cord_init = 1'b1;
                state_next    = S_CORD_ITER;
            end
            S_CORD_ITER:
            begin
                // a zero vector has angle 0 and skips the rotations
                if (stat.zero_vec)
                    state_next = S_ROUND;
                else
                begin
                    cmd.cord_step = 1'b1;
                    if (stat.cord_last)
                        state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (stat.out_space)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: rtl/mcah_dp.sv
// Datapath: config registers, calibration state, iterative CORDIC and output register.
`default_nettype none

module mcah_dp #(
    parameter int ATAN_STEPS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mcah_pkg::cmd_t                        cmd,
    output mcah_pkg::stat_t                            stat,
    input  wire logic                                  in_kind,
    input  wire logic signed [mcah_pkg::SAMPLE_W-1:0]  in_raw_x,
    input  wire logic signed [mcah_pkg::SAMPLE_W-1:0]  in_raw_y,
    input  wire logic signed [mcah_pkg::SAMPLE_W-1:0]  in_raw_z,
    input  wire logic                                  cfg_we,
    input  wire mcah_pkg::cfg_idx_t                    cfg_index,
    input  wire logic [mcah_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [mcah_pkg::HEADING_W-1:0]             out_heading,
    output mcah_pkg::status_t                          out_status
);

    localparam int SW = mcah_pkg::SAMPLE_W;
    localparam int AW = mcah_pkg::AXIS_W;
    localparam int VW = mcah_pkg::VEC_W;
    localparam int GW = mcah_pkg::ANG_W;
    localparam int STEPS_EFF = (ATAN_STEPS > mcah_pkg::ATAN_MAX_STEPS) ?
                               mcah_pkg::ATAN_MAX_STEPS : ATAN_STEPS;
    localparam int STEP_W = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_EFF - 1);

    // Configuration registers
    logic [mcah_pkg::THR_W-1:0]   reject_limit_reg;
    logic [mcah_pkg::THR_W-1:0]   arm_threshold_reg;
    logic [mcah_pkg::THR_W-1:0]   turn_threshold_reg;
    logic [mcah_pkg::COUNT_W-1:0] turns_needed_reg;
    logic signed [SW-1:0]         declination_reg;

    // Latched item
    logic                 kind_reg;
    logic signed [SW-1:0] raw_reg [3];

    // Calibration state
    logic                              calibrating_reg;
    logic signed [AW-1:0]              min_reg   [3];
    logic signed [AW-1:0]              max_reg   [3];
    logic                              armed_reg [3];
    logic [mcah_pkg::COUNT_W-1:0]      count_reg [3];
    logic signed [AW-1:0]              off_reg   [3];

    // CORDIC state
    logic signed [VW-1:0]              vx_reg;
    logic signed [VW-1:0]              vy_reg;
    logic signed [GW-1:0]              ang_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic                              zero_reg;
    logic signed [mcah_pkg::RND_W-1:0] rnd_reg;

    // Result staging and output register
    mcah_pkg::status_t              res_status_reg;
    logic [mcah_pkg::HEADING_W-1:0] res_heading_reg;
    logic                           out_valid_reg;
    mcah_pkg::status_t              out_status_reg;
    logic [mcah_pkg::HEADING_W-1:0] out_heading_reg;

    // Per-axis calibration terms
    logic [SW-1:0]                mag       [3];
    logic signed [AW-1:0]         sat       [3];
    logic                         armed_next[3];
    logic [mcah_pkg::COUNT_W-1:0] count_next[3];
    logic signed [AW-1:0]         off_next  [3];
    logic signed [AW:0]           mid_sum   [3];
    logic                         rejected;
    logic                         done;

    always_comb
    begin
        rejected = 1'b0;
        done     = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = raw_reg[a][SW-1] ? SW'(-raw_reg[a]) : raw_reg[a];
            if (raw_reg[a] < mcah_pkg::AXIS_LO)
                sat[a] = AW'(mcah_pkg::AXIS_LO);
            else if (raw_reg[a] > mcah_pkg::AXIS_HI)
                sat[a] = AW'(mcah_pkg::AXIS_HI);
            else
                sat[a] = raw_reg[a][AW-1:0];
            if (mag[a] > {1'b0, reject_limit_reg})
                rejected = 1'b1;
            // hysteresis turn detector
            armed_next[a] = armed_reg[a];
            count_next[a] = count_reg[a];
            if (armed_reg[a])
            begin
                if (mag[a] > {1'b0, turn_threshold_reg})
                begin
                    armed_next[a] = 1'b0;
                    if (count_reg[a] != '1)
                        count_next[a] = count_reg[a] + 1'b1;
                end
            end
            else if (mag[a] < {1'b0, arm_threshold_reg})
                armed_next[a] = 1'b1;
            if (count_reg[a] < turns_needed_reg)
                done = 1'b0;
            // midpoint, truncated toward zero
            mid_sum[a]  = {max_reg[a][AW-1], max_reg[a]} + {min_reg[a][AW-1], min_reg[a]};
            off_next[a] = AW'((mid_sum[a] + {{AW{1'b0}}, mid_sum[a][AW]}) >>> 1);
        end
    end

    // Offset correction and half-plane pre-rotation
    logic signed [SW-1:0] cx;
    logic signed [SW-1:0] cy;
    logic signed [SW:0]   cx17;
    logic signed [SW:0]   cy17;
    logic signed [SW:0]   ix;
    logic signed [SW:0]   iy;
    logic signed [GW-1:0] iz;

    always_comb
    begin
        cx   = raw_reg[0] - {{(SW-AW){off_reg[0][AW-1]}}, off_reg[0]};
        cy   = raw_reg[1] - {{(SW-AW){off_reg[1][AW-1]}}, off_reg[1]};
        cx17 = {cx[SW-1], cx};
        cy17 = {cy[SW-1], cy};
        ix   = cx17;
        iy   = cy17;
        iz   = '0;
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                ix = cy17;
                iy = -cx17;
                iz = mcah_pkg::QUARTER_ANGLE;
            end
            else
            begin
                ix = -cy17;
                iy = cx17;
                iz = -mcah_pkg::QUARTER_ANGLE;
            end
        end
    end

    // One CORDIC rotation
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic signed [GW-1:0] tab;

    always_comb
    begin
        xs  = vx_reg >>> step_reg;
        ys  = vy_reg >>> step_reg;
        tab = {{(GW-mcah_pkg::TAB_W){1'b0}}, mcah_pkg::atan_entry(5'(step_reg))};
    end

    // Declination add and rounding to 1/128 degree
    logic signed [GW:0] total;

    always_comb
    begin
        total = {ang_reg[GW-1], ang_reg}
              + {{(GW+1-SW-8){declination_reg[SW-1]}}, declination_reg, 8'd0}
              + (GW+1)'(128);
    end

    // Reduction into one full turn
    logic signed [mcah_pkg::WRAP_W-1:0] rw;
    logic signed [mcah_pkg::WRAP_W-1:0] rw_up1;
    logic signed [mcah_pkg::WRAP_W-1:0] rw_up2;
    logic signed [mcah_pkg::WRAP_W-1:0] rw_dn;
    logic signed [mcah_pkg::WRAP_W-1:0] rw_sel;

    always_comb
    begin
        rw     = {rnd_reg[mcah_pkg::RND_W-1], rnd_reg};
        rw_up1 = rw + mcah_pkg::FULL_TURN;
        rw_up2 = rw + mcah_pkg::TWO_TURNS;
        rw_dn  = rw - mcah_pkg::FULL_TURN;
        if (rw < 0)
            rw_sel = (rw_up1 < 0) ? rw_up2 : rw_up1;
        else if (rw >= mcah_pkg::FULL_TURN)
            rw_sel = rw_dn;
        else
            rw_sel = rw;
    end

    logic out_space;
    assign out_space = !out_valid_reg || out_ready;

    // Status to controller
    always_comb
    begin
        stat.kind        = kind_reg;
        stat.calibrating = calibrating_reg;
        stat.rejected    = rejected;
        stat.zero_vec    = zero_reg;
        stat.cord_last   = (step_reg == LAST_STEP);
        stat.out_space   = out_space;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_limit_reg   <= mcah_pkg::RST_REJECT_LIMIT;
            arm_threshold_reg  <= mcah_pkg::RST_ARM_THRESHOLD;
            turn_threshold_reg <= mcah_pkg::RST_TURN_THRESHOLD;
            turns_needed_reg   <= mcah_pkg::RST_TURNS_NEEDED;
            declination_reg    <= mcah_pkg::RST_DECLINATION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcah_pkg::REG_REJECT_LIMIT:   reject_limit_reg   <= cfg_data[mcah_pkg::THR_W-1:0];
                mcah_pkg::REG_ARM_THRESHOLD:  arm_threshold_reg  <= cfg_data[mcah_pkg::THR_W-1:0];
                mcah_pkg::REG_TURN_THRESHOLD: turn_threshold_reg <= cfg_data[mcah_pkg::THR_W-1:0];
                mcah_pkg::REG_TURNS_NEEDED:   turns_needed_reg   <= cfg_data[mcah_pkg::COUNT_W-1:0];
                mcah_pkg::REG_DECLINATION:    declination_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrating_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a]   <= '0;
                max_reg[a]   <= '0;
                armed_reg[a] <= 1'b0;
                count_reg[a] <= '0;
                off_reg[a]   <= '0;
            end
        end
        else if (cmd.start_cal)
        begin
            calibrating_reg <= 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a]   <= '0;
                max_reg[a]   <= '0;
                armed_reg[a] <= 1'b0;
                count_reg[a] <= '0;
            end
        end
        else if (cmd.cal_update)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (sat[a] < min_reg[a])
                    min_reg[a] <= sat[a];
                if (sat[a] > max_reg[a])
                    max_reg[a] <= sat[a];
                armed_reg[a] <= armed_next[a];
                count_reg[a] <= count_next[a];
            end
        end
        else if (cmd.cal_check && done)
        begin
            calibrating_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                off_reg[a] <= off_next[a];
        end
    end

    // Item latch, CORDIC iterations and result staging
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            raw_reg[0] <= in_raw_x;
            raw_reg[1] <= in_raw_y;
            raw_reg[2] <= in_raw_z;
        end
        if (cmd.cord_init)
        begin
            vx_reg   <= {{(VW-SW-9){ix[SW]}}, ix, 8'd0};
            vy_reg   <= {{(VW-SW-9){iy[SW]}}, iy, 8'd0};
            ang_reg  <= iz;
            step_reg <= '0;
            zero_reg <= (cx == 0) && (cy == 0);
        end
        else if (cmd.cord_step)
        begin
            if (vy_reg < 0)
            begin
                vx_reg  <= vx_reg - ys;
                vy_reg  <= vy_reg + xs;
                ang_reg <= ang_reg - tab;
            end
            else
            begin
                vx_reg  <= vx_reg + ys;
                vy_reg  <= vy_reg - xs;
                ang_reg <= ang_reg + tab;
            end
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.round)
            rnd_reg <= total[GW:8];
        if (cmd.start_cal)
        begin
            res_status_reg  <= mcah_pkg::ST_STARTED;
            res_heading_reg <= '0;
        end
        else if (cmd.reject)
        begin
            res_status_reg  <= mcah_pkg::ST_REJECTED;
            res_heading_reg <= '0;
        end
        else if (cmd.cal_check)
        begin
            res_status_reg  <= done ? mcah_pkg::ST_FINISHED : mcah_pkg::ST_USED;
            res_heading_reg <= '0;
        end
        else if (cmd.wrap)
        begin
            res_status_reg  <= mcah_pkg::ST_HEADING;
            res_heading_reg <= rw_sel[mcah_pkg::HEADING_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_status_reg  <= res_status_reg;
            out_heading_reg <= res_heading_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_heading = out_heading_reg;

    // Checks
    a_publish_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> out_space)
        else $error("result published while output register still full");

    a_heading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != mcah_pkg::ST_HEADING) |-> out_heading_reg == '0)
        else $error("non-heading result carries a heading");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mcah_pkg::ST_HEADING)
            |-> out_heading_reg < mcah_pkg::HEADING_W'(46080))
        else $error("heading outside one full turn");

    a_finish_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(calibrating_reg) |-> res_status_reg == mcah_pkg::ST_FINISHED)
        else $error("calibration ended without a finished result");

endmodule

`default_nettype wire

// File: rtl/magnetometer_calibrate_and_heading.sv
// Top level: magnetometer hard-iron calibration and atan2 compass heading.
//
// Channels: in_ch takes items (kind 0 = x/y/z sample, kind 1 = start calibration);
// out_ch returns exactly one result per item (heading in 1/128 degree and status);
// cfg_ch writes the five configuration registers and is always ready.
// Items are handled one at a time. A heading passes from the input transfer through
// decision, CORDIC setup, the CORDIC iterations, rounding and wrapping to the output
// register; the iterations reuse one shift/add stage once per step, and an item whose
// corrected x and y are both zero skips the iterations. A calibration sample is recorded
// and then checked before delivery; a start command or a rejected sample skips the check.
// The input is ready again in the cycle after the result is loaded into the register.
// The output register lets the block take the next item while a result waits;
// if the receiver stalls, the next result is held internally until the register
// frees, and no further item is taken meanwhile.
// Reset puts the registers at their defaults, clears calibration state and offsets,
// and drops out valid.
`default_nettype none

module magnetometer_calibrate_and_heading #(
    parameter int ATAN_STEPS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcah_in_if.sink     in_ch,
    mcah_out_if.source  out_ch,
    mcah_cfg_if.sink    cfg_ch
);

    mcah_pkg::cmd_t  cmd;
    mcah_pkg::stat_t stat;
    logic            in_ready;

    // Configuration writes are accepted every cycle
    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = in_ready;

    // Sequencer
    mcah_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    mcah_dp #(
        .ATAN_STEPS (ATAN_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (in_ch.kind),
        .in_raw_x    (in_ch.raw_x),
        .in_raw_y    (in_ch.raw_y),
        .in_raw_z    (in_ch.raw_z),
        .cfg_we      (cfg_ch.valid),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_heading (out_ch.heading),
        .out_status  (out_ch.status)
    );

endmodule

`default_nettype wire
